// ===== src/bdcc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bdcc_pkg
// Shared types and constants of the button debounce and click counter.
// ---------------------------------------------------------------------------
package bdcc_pkg;

   localparam int TIME_W        = 32;
   localparam int CFG_W         = 16;
   localparam int RESULT_W      = 8;
   localparam int MAX_CLICKS_DF = 127;
   localparam int REQ_DATA_W    = 40;
   localparam int RSP_DATA_W    = 16;
   localparam int CSR_IDX_W     = 1;

   localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
   localparam logic [CFG_W-1:0] TIMEOUT_RST  = 16'd250;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE_MS = 1'b0,
      CSR_TIMEOUT_MS  = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [CFG_W-1:0] click_timeout_ms;
      logic [CFG_W-1:0] debounce_ms;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              pin_level;
   } req_type;

   typedef struct packed {
      logic signed [RESULT_W-1:0] click_result;
      logic                       level_changed;
      logic                       debounced_level;
   } rsp_type;

endpackage

// ===== src/bdcc_track.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bdcc_track
// Debounce and click tracking state with its single-pass next-state logic.
// ---------------------------------------------------------------------------
module bdcc_track #(
   parameter int MAX_CLICKS = bdcc_pkg::MAX_CLICKS_DF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  bdcc_pkg::req_type item,
   input  bdcc_pkg::cfg_type cfg,
   output bdcc_pkg::rsp_type result
);
   import bdcc_pkg::*;

   localparam int CNT_W = $clog2(MAX_CLICKS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CLICKS);

   logic                stable_ff,  stable_in;
   logic                raw_ff,     raw_in;
   logic [TIME_W-1:0]   edge_ff,    edge_in;
   logic [TIME_W-1:0]   press_ff,   press_in;
   logic [CNT_W-1:0]    count_ff,   count_in;
   logic [RESULT_W-1:0] report_ff,  report_in;

   logic                changed;
   logic                frozen;
   logic                press;
   logic [CNT_W-1:0]    count_pre;
   logic [TIME_W-1:0]   since_edge;
   logic [TIME_W-1:0]   since_press;
   logic [RESULT_W-1:0] count_ext;

   always_comb begin
      raw_in     = item.pin_level;
      edge_in    = (raw_ff != item.pin_level) ? item.now_ms : edge_ff;
      since_edge = item.now_ms - edge_in;
      changed    = (since_edge >= TIME_W'(cfg.debounce_ms)) && (stable_ff != item.pin_level);
      stable_in  = changed ? item.pin_level : stable_ff;

      press      = stable_in && changed;
      frozen     = stable_in && !changed && report_ff[RESULT_W-1];
      press_in   = press ? item.now_ms : press_ff;
      count_pre  = (press && (count_ff < CNT_MAX)) ? count_ff + CNT_W'(1) : count_ff;

      since_press = item.now_ms - press_in;
      count_ext   = RESULT_W'(count_pre);
      report_in   = report_ff;
      count_in    = count_pre;
      if (!frozen) begin
         report_in = '0;
         if ((count_pre != '0) && (since_press > TIME_W'(cfg.click_timeout_ms))) begin
            report_in = stable_in ? -count_ext : count_ext;
            count_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= 1'b0;
         raw_ff    <= 1'b0;
         edge_ff   <= '0;
         press_ff  <= '0;
         count_ff  <= '0;
         report_ff <= '0;
      end else if (advance) begin
         stable_ff <= stable_in;
         raw_ff    <= raw_in;
         edge_ff   <= edge_in;
         press_ff  <= press_in;
         count_ff  <= count_in;
         report_ff <= report_in;
      end
   end

   assign result.debounced_level = stable_in;
   assign result.level_changed   = changed;
   assign result.click_result    = report_in;

endmodule

// ===== src/button_debounce_click_counter_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// button_debounce_click_counter_core
// Debounces a sampled button pin and reports multi-click and hold events.
// ---------------------------------------------------------------------------
// Each sample transaction (pin level plus millisecond timestamp) yields one
// result transaction: debounced level, a level-change flag and the click
// report (0 none, +n clicks after release, -n clicks while still held).
// Throughput is one sample per clock while the receiver takes results; a sample
// passes the input register, the combinational tracking logic and the result register.
// The CSR port sets debounce_ms (index 0) and click_timeout_ms (index 1); the user must
// write it only while no sample is in flight, as the block itself does not enforce this.
module button_debounce_click_counter_core #(
   parameter int MAX_CLICKS = bdcc_pkg::MAX_CLICKS_DF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] pin_level, [32:1] now_ms, [39:33] zero
   input  logic [bdcc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] debounced_level, [1] level_changed, [9:2] click_result, [15:10] zero
   output logic [bdcc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [bdcc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bdcc_pkg::CFG_W-1:0]          csr_wdata
);
   import bdcc_pkg::*;

   localparam int REQ_BITS = $bits(req_type);
   localparam int RSP_BITS = $bits(rsp_type);

   logic    stage_vld_ff, stage_vld_in;
   req_type stage_ff;
   logic    rsp_vld_ff,   rsp_vld_in;
   rsp_type rsp_ff;
   cfg_type cfg_ff;
   rsp_type result;
   logic    advance;
   logic    take;

   assign advance      = stage_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready   = !stage_vld_ff || advance;
   assign take         = req_tvalid && req_tready;
   assign stage_vld_in = take || (stage_vld_ff && !advance);
   assign rsp_vld_in   = advance || (rsp_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_ff <= req_type'(req_tdata[REQ_BITS-1:0]);
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms      <= DEBOUNCE_RST;
         cfg_ff.click_timeout_ms <= TIMEOUT_RST;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_DEBOUNCE_MS: cfg_ff.debounce_ms      <= csr_wdata;
            CSR_TIMEOUT_MS:  cfg_ff.click_timeout_ms <= csr_wdata;
            default: ;
         endcase
      end
   end

   bdcc_track #(
      .MAX_CLICKS(MAX_CLICKS)
   ) u_track (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (stage_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_BITS){1'b0}}, rsp_ff};

endmodule

// ===== src/bdcc_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bdcc_sva_checker
// Port-level checks of the button debounce and click counter.
// ---------------------------------------------------------------------------
module bdcc_sva_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bdcc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bdcc_pkg::*;

   ap_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   ap_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("sample refused with empty result register");

   ap_held_report: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> rsp_tdata[0] && (rsp_tdata[9:2] != 8'h80))
      else $error("negative report without held button");

   ap_release_report: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[9] && (rsp_tdata[9:2] != 8'h00) |-> !rsp_tdata[0])
      else $error("positive report while button held");

endmodule

bind button_debounce_click_counter_core bdcc_sva_checker u_bdcc_sva_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== sim/bdcc_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bdcc_checker
// Tracks the button debounce and click counter and compares its results.
// ---------------------------------------------------------------------------
// Watches the sample, result and CSR ports of the core. Every accepted sample
// runs through a local debounce and click tracker that keeps its own copy of
// the registers, and the predicted result is queued. Every accepted result is
// checked field by field against the oldest queued prediction. The number of
// predictions still waiting and the number of failures go to the top.
module bdcc_checker
   import bdcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata,
   output int                    fail_count,
   output int                    outstanding
);

   logic [CFG_W-1:0]           debounce_ms_q;
   logic [CFG_W-1:0]           timeout_ms_q;
   logic                       stable_q;
   logic                       raw_q;
   logic [TIME_W-1:0]          edge_time_q;
   logic [TIME_W-1:0]          press_time_q;
   logic [6:0]                 clicks_q;
   logic signed [RESULT_W-1:0] report_q;
   rsp_type                    expected_q[$];

   function automatic rsp_type track_sample(input req_type smp);
      rsp_type           res;
      logic              changed;
      logic              frozen;
      logic [TIME_W-1:0] since_edge;
      logic [TIME_W-1:0] since_press;
      if (raw_q != smp.pin_level) begin
         edge_time_q = smp.now_ms;
      end
      since_edge = smp.now_ms - edge_time_q;
      changed    = 1'b0;
      if (since_edge >= TIME_W'(debounce_ms_q) && stable_q != smp.pin_level) begin
         stable_q = smp.pin_level;
         changed  = 1'b1;
      end
      raw_q = smp.pin_level;

      // hold a negative report while the button stays down
      frozen = 1'b0;
      if (stable_q) begin
         if (changed) begin
            press_time_q = smp.now_ms;
            if (clicks_q < MAX_CLICKS_DF) begin
               clicks_q = clicks_q + 7'd1;
            end
         end else if (report_q < 0) begin
            frozen = 1'b1;
         end
      end

      if (!frozen) begin
         since_press = smp.now_ms - press_time_q;
         report_q    = '0;
         if (clicks_q != 7'd0 && since_press > TIME_W'(timeout_ms_q)) begin
            report_q = stable_q ? -$signed({1'b0, clicks_q}) : $signed({1'b0, clicks_q});
            clicks_q = '0;
         end
      end

      res.debounced_level = stable_q;
      res.level_changed   = changed;
      res.click_result    = report_q;
      return res;
   endfunction

   always @(posedge clock) begin : track
      rsp_type got;
      rsp_type want;
      int      errs;
      errs = 0;
      if (reset) begin
         debounce_ms_q = DEBOUNCE_RST;
         timeout_ms_q  = TIMEOUT_RST;
         stable_q      = 1'b0;
         raw_q         = 1'b0;
         edge_time_q   = '0;
         press_time_q  = '0;
         clicks_q      = '0;
         report_q      = '0;
         expected_q.delete();
         outstanding <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_idx_type'(csr_index))
               CSR_DEBOUNCE_MS: debounce_ms_q = csr_wdata;
               CSR_TIMEOUT_MS:  timeout_ms_q  = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_q.push_back(track_sample(req_type'(req_tdata[$bits(req_type)-1:0])));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
            if (expected_q.size() == 0) begin
               $error("result transaction with nothing expected: tdata %0h", rsp_tdata);
               errs++;
            end else begin
               want = expected_q.pop_front();
               if (got.debounced_level !== want.debounced_level) begin
                  $error("debounced_level mismatch: expected %0d, actual %0d",
                         want.debounced_level, got.debounced_level);
                  errs++;
               end
               if (got.level_changed !== want.level_changed) begin
                  $error("level_changed mismatch: expected %0d, actual %0d",
                         want.level_changed, got.level_changed);
                  errs++;
               end
               if (got.click_result !== want.click_result) begin
                  $error("click_result mismatch: expected %0d, actual %0d",
                         want.click_result, got.click_result);
                  errs++;
               end
            end
         end
         outstanding <= expected_q.size();
      end
      if (errs != 0) begin
         fail_count <= fail_count + errs;
      end
   end

endmodule

// ===== sim/tb_button_debounce_click_counter_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_button_debounce_click_counter_core
// Stimulus and verdict for the button debounce and click counter core.
// ---------------------------------------------------------------------------
// Drives pin samples with timestamps: a short directed run over the edges of
// the timing rules, then phases of random button gestures (bounced presses,
// multi-click bursts, long holds, a saturating burst) mixed with noise and
// timestamp jumps that wrap. Each phase sets new register values and its own
// amount of sender idling and receiver stalls; one phase holds the receiver
// off long enough to back the core up. Checking is done by bdcc_checker.
module tb_button_debounce_click_counter_core;
   import bdcc_pkg::*;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_ITEMS     = 15;
   localparam int NUM_PHASES      = 9;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wr_en  = 1'b0;
   csr_idx_type           csr_index  = CSR_DEBOUNCE_MS;
   logic [CFG_W-1:0]      csr_wdata  = '0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int                fail_count;
   int                outstanding;
   int                idle_cycles   = 0;
   int                items_sent    = 0;
   int                tx_idle_pct   = 0;
   int                rx_stall_pct  = 0;
   bit                hold_off_trig = 1'b0;
   bit                hold_off_seen = 1'b0;
   int                hold_left     = 0;
   logic [TIME_W-1:0] now_ms        = '0;
   int unsigned       cur_deb       = DEBOUNCE_RST;
   int unsigned       cur_tmo       = TIMEOUT_RST;

   always #5 clock = ~clock;

   button_debounce_click_counter_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   bdcc_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_off_trig != hold_off_seen) begin
         hold_off_seen <= hold_off_trig;
         hold_left     <= HOLD_OFF_CYCLES;
         rsp_tready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic send_item(input logic pin, input logic [TIME_W-1:0] stamp);
      req_type smp;
      while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      smp.pin_level = pin;
      smp.now_ms    = stamp;
      req_tdata  <= {{(REQ_DATA_W - $bits(req_type)){1'b0}}, smp};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_sample(input logic pin, input int unsigned dt);
      now_ms = now_ms + dt;
      send_item(pin, now_ms);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_config(input int unsigned deb, input int unsigned tmo);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DEBOUNCE_MS;
      csr_wdata <= deb[CFG_W-1:0];
      @(posedge clock);
      csr_index <= CSR_TIMEOUT_MS;
      csr_wdata <= tmo[CFG_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_deb = deb;
      cur_tmo = tmo;
   endtask

   // hold one level for at least span ms, in a few samples
   task automatic hold_level(input logic pin, input int unsigned span);
      int unsigned n;
      int unsigned used;
      int unsigned dt;
      send_sample(pin, $urandom_range(0, 3));
      n    = $urandom_range(1, 3);
      used = 0;
      for (int k = 1; k < n; k++) begin
         dt   = $urandom_range(0, span / n);
         used = used + dt;
         send_sample(pin, dt);
      end
      send_sample(pin, span - used + $urandom_range(0, 2));
   endtask

   task automatic bounce(input logic pin);
      int unsigned n;
      n = $urandom_range(0, 3);
      for (int k = 0; k < n; k++) begin
         send_sample((k % 2) ? pin : !pin, $urandom_range(0, cur_deb / 2));
      end
   endtask

   task automatic gesture(input int unsigned clicks, input bit hold_end);
      for (int c = 0; c < clicks; c++) begin
         bounce(1'b1);
         hold_level(1'b1, cur_deb + $urandom_range(0, cur_tmo / 4));
         if (c == clicks - 1 && hold_end) begin
            hold_level(1'b1, cur_tmo + $urandom_range(1, 50));
            hold_level(1'b1, $urandom_range(0, cur_tmo));
         end
         bounce(1'b0);
         hold_level(1'b0, cur_deb + ((c == clicks - 1) ? 0 : $urandom_range(0, cur_tmo / 4)));
      end
      hold_level(1'b0, cur_tmo + $urandom_range(0, 20));
   endtask

   task automatic noise();
      int unsigned n;
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 3) == 0) begin
            send_sample(1'($urandom_range(0, 1)), $urandom());
         end else begin
            send_sample(1'($urandom_range(0, 1)),
                        $urandom_range(0, cur_deb + cur_tmo / 2 + 1));
         end
      end
   endtask

   initial begin
      int unsigned deb;
      int unsigned tmo;
      int          target;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset values: one click, then a press and release across the wrap
      send_item(1'b1, 32'd0);
      send_item(1'b1, 32'd49);
      send_item(1'b1, 32'd50);
      send_item(1'b0, 32'd100);
      send_item(1'b0, 32'd150);
      send_item(1'b0, 32'd400);
      send_item(1'b0, 32'd401);
      send_item(1'b1, 32'hFFFF_FFF0);
      send_item(1'b1, 32'h0000_0030);
      send_item(1'b0, 32'h0000_0040);
      send_item(1'b0, 32'h0000_0080);
      send_item(1'b0, 32'h0000_0200);
      send_item(1'b1, 32'hFFFF_FFFF);
      send_item(1'b0, 32'hFFFF_FFFF);

      // zero debounce and timeout: press on the same sample, held report latched
      wait_drained();
      set_config(0, 0);
      send_item(1'b1, 32'd1000);
      send_item(1'b1, 32'd1000);
      send_item(1'b1, 32'd1001);
      send_item(1'b1, 32'd1001);
      send_item(1'b1, 32'd5000);
      send_item(1'b0, 32'd5001);
      send_item(1'b1, 32'd5002);
      send_item(1'b0, 32'd5002);
      send_item(1'b0, 32'd5003);

      now_ms = 32'hFFFF_0000;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         case (ph)
            0: begin deb = 50; tmo = 250; tx_idle_pct = 0; rx_stall_pct <= 0; end
            1: begin deb = 0; tmo = 65535; tx_idle_pct = 60; rx_stall_pct <= 0; end
            2: begin deb = 65535; tmo = 65535; tx_idle_pct = 0; rx_stall_pct <= 60; end
            3: begin deb = 0; tmo = 0; tx_idle_pct = 15; rx_stall_pct <= 15; end
            4: begin deb = 65535; tmo = 0; tx_idle_pct = 0; rx_stall_pct <= 0; end
            5: begin
               deb = $urandom_range(0, 65535);
               tmo = $urandom_range(0, 65535);
               tx_idle_pct = 60;
               rx_stall_pct <= 0;
            end
            6: begin
               deb = $urandom_range(0, 100);
               tmo = $urandom_range(0, 600);
               tx_idle_pct = 0;
               rx_stall_pct <= 60;
            end
            7: begin
               deb = $urandom_range(0, 65535);
               tmo = $urandom_range(0, 65535);
               tx_idle_pct = 15;
               rx_stall_pct <= 15;
            end
            default: begin deb = 5; tmo = 40; tx_idle_pct = 0; rx_stall_pct <= 0; end
         endcase
         set_config(deb, tmo);
         if (ph == 4) begin
            hold_off_trig <= ~hold_off_trig;
         end
         // run the click count into saturation
         if (ph == 1) begin
            gesture(135, 1'b0);
         end
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            if ($urandom_range(0, 9) < 7) begin
               gesture(($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4),
                       ($urandom_range(0, 3) == 0));
            end else begin
               noise();
            end
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/bdcc_pkg.sv
src/bdcc_track.sv
src/button_debounce_click_counter_core.sv
src/bdcc_checker.sv
sim/bdcc_checker.sv
sim/tb_button_debounce_click_counter_core.sv
